>>> sv/stq_pkg.sv
// Shared types, codes and sizes of the sorted timer queue.
package stq_pkg;

  localparam int unsigned TICK_W         = 24;
  localparam int unsigned WRAP_W         = 32;
  localparam int unsigned CTX_W          = 32;
  localparam int unsigned IDX_W          = 4;
  localparam int unsigned TCNT_W         = 5;
  localparam int unsigned NUM_TIMERS_DEF = 16;
  localparam logic [TICK_W+1:0] DUE_SLACK = (TICK_W+2)'(3);

  localparam logic [TICK_W-1:0] MIN_TIMEOUT_RST = TICK_W'(5);
  localparam logic [TCNT_W-1:0] TIMER_COUNT_RST = TCNT_W'(16);

  // Action codes.
  localparam logic [2:0] ACT_CREATE   = 3'd0;
  localparam logic [2:0] ACT_START    = 3'd1;
  localparam logic [2:0] ACT_STOP     = 3'd2;
  localparam logic [2:0] ACT_STOP_ALL = 3'd3;
  localparam logic [2:0] ACT_CHECK    = 3'd4;

  // Status codes.
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_INVALID     = 3'd1;
  localparam logic [2:0] ST_NOT_ALLOC   = 3'd2;
  localparam logic [2:0] ST_NO_FREE     = 3'd3;
  localparam logic [2:0] ST_ALREADY_RUN = 3'd4;

  // Register indexes.
  localparam logic CFG_MIN_TIMEOUT = 1'b0;
  localparam logic CFG_TIMER_COUNT = 1'b1;

  // Word kinds.
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef struct packed {
    logic [TICK_W-1:0] tick;
    logic [WRAP_W-1:0] wrap;
    logic [TICK_W-1:0] intv;
    logic [CTX_W-1:0]  ctx;
  } rec_t;

endpackage

>>> sv/sorted_timer_queue_unit.sv
// Sorted timer queue: timer pool and expiry-sorted running list.
//
// Channel   Dir  Words                       Contents
// s_axis    in   one per action              tuser action; tdata timer fields
// m_axis    out  reports, then one status    tuser kind; tlast on the status
// cfg       in   register writes             min_timeout, timer_count
//
// Create scans the pool for the lowest free id; stop-all and the rejected
// actions go straight on to the status word. Start and check walk the list
// through a memory port with registered read data, a read state and a
// compare state for each entry passed; a check pops each due head and runs
// one insert walk for every repeated timer. Input reopens in the cycle
// after the status word is loaded.
// Reset clears the allocation, running and listed bits and the list head;
// the memories need no clearing pass. A stalled output holds the walk in place.
module sorted_timer_queue_unit #(
  parameter int unsigned NUM_TIMERS = stq_pkg::NUM_TIMERS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // cfg write port
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [23:0] cfg_data_i,
  // tdata: timer_index[3:0], timeout_len[27:4], repeat_mode[28],
  //        user_context[60:29], counter_now[84:61], zero pad[87:85]
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [87:0] s_axis_tdata_i,
  // tuser: action[2:0]
  input  logic [2:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // tdata: status[2:0], result_timer[6:3], expired_context[38:7],
  //        compare_valid[39], compare_value[63:40]
  output logic [63:0] m_axis_tdata_o,
  // tuser: kind[0]
  output logic        m_axis_tuser_o,
  output logic        m_axis_tlast_o
);

  localparam int unsigned IW = $clog2(NUM_TIMERS);
  localparam int unsigned LW = $clog2(NUM_TIMERS + 1);
  localparam int unsigned CW = LW;
  localparam int unsigned TW = stq_pkg::TICK_W;
  localparam int unsigned WW = stq_pkg::WRAP_W;
  localparam logic [LW-1:0] NO_LINK = LW'(NUM_TIMERS);

  typedef enum logic [3:0] {
    S_IDLE, S_CREATE, S_INS_RD, S_INS_CMP, S_INS_LINK, S_INS_LINK2,
    S_FIND_RD, S_FIND_NX, S_CHK_HEAD, S_CHK_CMP, S_FINAL, S_FIN_EMIT
  } state_e;

  state_e st_q;

  // configuration
  logic [TW-1:0]              min_q;
  logic [stq_pkg::TCNT_W-1:0] tc_q;

  // per-timer flags
  logic [NUM_TIMERS-1:0] alloc_q, rep_q, run_q, listed_q;

  // list and counter state
  logic [LW-1:0] head_q;
  logic [WW-1:0] wc_q;
  logic [TW-1:0] last_q;

  // action in work
  logic [IW-1:0] idx_q;
  logic          new_rep_q;
  logic [2:0]    status_q;
  logic [3:0]    tid_q;
  logic [CW-1:0] ci_q, pops_q;
  logic [LW-1:0] cur_q, prev_q;
  logic [IW-1:0] ins_id_q;
  logic [TW-1:0] ins_tick_q;
  logic [WW-1:0] ins_wrap_q;
  logic          ins_chk_q;

  // output word register
  logic                     out_valid_q, out_kind_q, out_cv_q, out_last_q;
  logic [2:0]               out_status_q;
  logic [3:0]               out_tid_q;
  logic [stq_pkg::CTX_W-1:0] out_ctx_q;
  logic [TW-1:0]            out_cval_q;

  // input fields
  logic [2:0]                in_act;
  logic [3:0]                in_idx;
  logic [TW-1:0]             in_tmo, in_now;
  logic                      in_rep;
  logic [stq_pkg::CTX_W-1:0] in_ctx;

  assign in_act = s_axis_tuser_i;
  assign in_idx = s_axis_tdata_i[3:0];
  assign in_tmo = s_axis_tdata_i[27:4];
  assign in_rep = s_axis_tdata_i[28];
  assign in_ctx = s_axis_tdata_i[60:29];
  assign in_now = s_axis_tdata_i[84:61];

  logic accept, slot_free;
  assign s_axis_tready_o = (st_q == S_IDLE);
  assign accept    = s_axis_tvalid_i && s_axis_tready_o;
  assign slot_free = !out_valid_q || m_axis_tready_i;

  // active timer count, clipped to the pool
  logic [CW-1:0] cnt;
  always_comb begin
    if (32'(tc_q) > 32'(NUM_TIMERS)) cnt = CW'(NUM_TIMERS);
    else cnt = CW'(tc_q);
  end

  logic [IW-1:0] in_id;
  logic          idx_bad, in_alloc, in_listed;
  assign in_id     = IW'(in_idx);
  assign idx_bad   = 32'(in_idx) >= 32'(cnt);
  assign in_alloc  = alloc_q[in_id];
  assign in_listed = listed_q[in_id];

  // counter sample
  logic [WW-1:0] wc_smp;
  assign wc_smp = (in_now < last_q) ? wc_q + WW'(1) : wc_q;

  logic start_go;
  assign start_go = accept && (in_act == stq_pkg::ACT_START) && !idx_bad &&
                    (in_tmo >= min_q) && in_alloc && !in_listed;

  // memory ports
  logic [IW-1:0] rd_addr;
  logic          rec_we, link_we;
  logic [IW-1:0] rec_wa, link_wa;
  stq_pkg::rec_t rec_wd, rec_rd;
  logic [LW-1:0] link_wd, link_rd;

  stq_store #(.NUM_TIMERS(NUM_TIMERS)) u_store (
    .clk_i     (clk_i),
    .rd_addr_i (rd_addr),
    .rec_we_i  (rec_we),
    .rec_wa_i  (rec_wa),
    .rec_wd_i  (rec_wd),
    .link_we_i (link_we),
    .link_wa_i (link_wa),
    .link_wd_i (link_wd),
    .rec_rd_o  (rec_rd),
    .link_rd_o (link_rd)
  );

  // address the walk cursor in the walk states, else the list head
  logic [LW-1:0] rd_link;
  assign rd_link = (st_q == S_INS_RD || st_q == S_FIND_RD) ? cur_q : head_q;
  assign rd_addr = (rd_link < NO_LINK) ? rd_link[IW-1:0] : '0;

  // due test on the head record
  logic          head_due, chk_pop;
  logic [IW-1:0] head_id;
  assign head_id  = head_q[IW-1:0];
  assign head_due = ((rec_rd.wrap == wc_q) &&
                     ({2'b00, rec_rd.tick} <= {2'b00, last_q} + stq_pkg::DUE_SLACK)) ||
                    (rec_rd.wrap < wc_q);
  assign chk_pop  = (st_q == S_CHK_CMP) && head_due && slot_free;

  // load the output register with a report or with the status word
  logic out_load;
  assign out_load = chk_pop || ((st_q == S_FIN_EMIT) && slot_free);

  // expiry of a new insert: start uses the fresh sample, check the held one
  logic [TW-1:0] base_tick, add_tick;
  logic [WW-1:0] base_wrap, ins_wrap;
  logic [TW:0]   tsum;
  always_comb begin
    if (st_q == S_IDLE) begin
      base_tick = in_now;
      add_tick  = in_tmo;
      base_wrap = wc_smp;
    end else begin
      base_tick = last_q;
      add_tick  = rec_rd.intv;
      base_wrap = wc_q;
    end
    tsum     = {1'b0, base_tick} + {1'b0, add_tick};
    ins_wrap = base_wrap + WW'(tsum[TW]);
  end

  logic ins_brk;
  assign ins_brk = (ins_wrap_q < rec_rd.wrap) ||
                   ((ins_wrap_q == rec_rd.wrap) && (ins_tick_q < rec_rd.tick));

  // memory writes
  always_comb begin
    rec_we  = 1'b0;
    rec_wa  = '0;
    rec_wd  = '{tick: tsum[TW-1:0], wrap: ins_wrap, intv: add_tick, ctx: in_ctx};
    link_we = 1'b0;
    link_wa = '0;
    link_wd = cur_q;
    case (st_q)
      S_IDLE: begin
        rec_we = start_go;
        rec_wa = in_id;
      end
      S_CHK_CMP: begin
        rec_we     = chk_pop && rep_q[head_id];
        rec_wa     = head_id;
        rec_wd.ctx = rec_rd.ctx;
      end
      S_INS_LINK: begin
        link_we = 1'b1;
        link_wa = ins_id_q;
        link_wd = cur_q;
      end
      S_INS_LINK2: begin
        link_we = 1'b1;
        link_wa = prev_q[IW-1:0];
        link_wd = LW'(ins_id_q);
      end
      S_FIND_NX: begin
        link_we = (cur_q == LW'(idx_q)) && (prev_q != NO_LINK);
        link_wa = prev_q[IW-1:0];
        link_wd = link_rd;
      end
      default: begin
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= stq_pkg::MIN_TIMEOUT_RST;
      tc_q  <= stq_pkg::TIMER_COUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        stq_pkg::CFG_MIN_TIMEOUT: min_q <= cfg_data_i[TW-1:0];
        stq_pkg::CFG_TIMER_COUNT: tc_q  <= cfg_data_i[stq_pkg::TCNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer, flags and output word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      alloc_q     <= '0;
      run_q       <= '0;
      listed_q    <= '0;
      head_q      <= NO_LINK;
      wc_q        <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // hold a stalled word, drop it once taken
      out_valid_q <= out_load || (out_valid_q && !m_axis_tready_i);
      case (st_q)
        S_IDLE: begin
          if (accept) begin
            idx_q     <= in_id;
            new_rep_q <= in_rep;
            tid_q     <= '0;
            ci_q      <= '0;
            pops_q    <= '0;
            cur_q     <= head_q;
            prev_q    <= NO_LINK;
            case (in_act)
              stq_pkg::ACT_CREATE: begin
                status_q <= stq_pkg::ST_OK;
                st_q     <= S_CREATE;
              end
              stq_pkg::ACT_START: begin
                if (idx_bad || in_tmo < min_q) begin
                  status_q <= stq_pkg::ST_INVALID;
                  st_q     <= S_FINAL;
                end else if (!in_alloc) begin
                  status_q <= stq_pkg::ST_NOT_ALLOC;
                  st_q     <= S_FINAL;
                end else begin
                  wc_q   <= wc_smp;
                  last_q <= in_now;
                  if (in_listed) begin
                    status_q <= stq_pkg::ST_ALREADY_RUN;
                    st_q     <= S_FINAL;
                  end else begin
                    // record written this cycle; now sort it in
                    status_q     <= stq_pkg::ST_OK;
                    run_q[in_id] <= 1'b1;
                    ins_id_q     <= in_id;
                    ins_tick_q   <= tsum[TW-1:0];
                    ins_wrap_q   <= ins_wrap;
                    ins_chk_q    <= 1'b0;
                    st_q         <= S_INS_RD;
                  end
                end
              end
              stq_pkg::ACT_STOP: begin
                if (idx_bad) begin
                  status_q <= stq_pkg::ST_INVALID;
                  st_q     <= S_FINAL;
                end else if (!in_alloc) begin
                  status_q <= stq_pkg::ST_NOT_ALLOC;
                  st_q     <= S_FINAL;
                end else begin
                  status_q     <= stq_pkg::ST_OK;
                  run_q[in_id] <= 1'b0;
                  st_q         <= in_listed ? S_FIND_RD : S_FINAL;
                end
              end
              stq_pkg::ACT_STOP_ALL: begin
                status_q <= stq_pkg::ST_OK;
                head_q   <= NO_LINK;
                listed_q <= '0;
                for (int i = 0; i < NUM_TIMERS; i++) begin
                  if (32'(i) < 32'(cnt)) run_q[i] <= 1'b0;
                end
                st_q <= S_FINAL;
              end
              stq_pkg::ACT_CHECK: begin
                status_q <= stq_pkg::ST_OK;
                wc_q     <= wc_smp;
                last_q   <= in_now;
                st_q     <= S_CHK_HEAD;
              end
              default: begin
                status_q <= stq_pkg::ST_INVALID;
                st_q     <= S_FINAL;
              end
            endcase
          end
        end
        S_CREATE: begin
          // scan for the lowest free id
          if (ci_q >= cnt) begin
            status_q <= stq_pkg::ST_NO_FREE;
            st_q     <= S_FINAL;
          end else if (!alloc_q[ci_q[IW-1:0]]) begin
            alloc_q[ci_q[IW-1:0]] <= 1'b1;
            rep_q[ci_q[IW-1:0]]   <= new_rep_q;
            tid_q                 <= 4'(ci_q);
            st_q                  <= S_FINAL;
          end else begin
            ci_q <= ci_q + CW'(1);
          end
        end
        S_INS_RD: begin
          if (cur_q == NO_LINK) st_q <= S_INS_LINK;
          else st_q <= S_INS_CMP;
        end
        S_INS_CMP: begin
          if (ins_brk) begin
            st_q <= S_INS_LINK;
          end else begin
            prev_q <= cur_q;
            cur_q  <= link_rd;
            st_q   <= S_INS_RD;
          end
        end
        S_INS_LINK: begin
          listed_q[ins_id_q] <= 1'b1;
          if (prev_q == NO_LINK) begin
            head_q <= LW'(ins_id_q);
            st_q   <= ins_chk_q ? S_CHK_HEAD : S_FINAL;
          end else begin
            st_q <= S_INS_LINK2;
          end
        end
        S_INS_LINK2: st_q <= ins_chk_q ? S_CHK_HEAD : S_FINAL;
        S_FIND_RD: st_q <= S_FIND_NX;
        S_FIND_NX: begin
          if (cur_q == LW'(idx_q)) begin
            // unlink; predecessor link is written by the memory port
            listed_q[idx_q] <= 1'b0;
            if (prev_q == NO_LINK) head_q <= link_rd;
            st_q <= S_FINAL;
          end else begin
            prev_q <= cur_q;
            cur_q  <= link_rd;
            st_q   <= S_FIND_RD;
          end
        end
        S_CHK_HEAD: begin
          if (head_q == NO_LINK || pops_q == CW'(NUM_TIMERS)) st_q <= S_FINAL;
          else st_q <= S_CHK_CMP;
        end
        S_CHK_CMP: begin
          if (!head_due) begin
            st_q <= S_FINAL;
          end else if (slot_free) begin
            // pop the head and report it
            out_kind_q   <= stq_pkg::KIND_REPORT;
            out_status_q <= stq_pkg::ST_OK;
            out_tid_q    <= 4'(head_id);
            out_ctx_q    <= rec_rd.ctx;
            out_cv_q     <= 1'b0;
            out_cval_q   <= '0;
            out_last_q   <= 1'b0;
            listed_q[head_id] <= 1'b0;
            head_q <= link_rd;
            pops_q <= pops_q + CW'(1);
            if (rep_q[head_id]) begin
              ins_id_q   <= head_id;
              ins_tick_q <= tsum[TW-1:0];
              ins_wrap_q <= ins_wrap;
              ins_chk_q  <= 1'b1;
              cur_q      <= link_rd;
              prev_q     <= NO_LINK;
              st_q       <= S_INS_RD;
            end else begin
              st_q <= S_CHK_HEAD;
            end
          end
        end
        S_FINAL: st_q <= S_FIN_EMIT;
        S_FIN_EMIT: begin
          if (slot_free) begin
            out_kind_q   <= stq_pkg::KIND_STATUS;
            out_status_q <= status_q;
            out_tid_q    <= tid_q;
            out_ctx_q    <= '0;
            out_cv_q     <= (head_q != NO_LINK);
            out_cval_q   <= (head_q != NO_LINK) ? rec_rd.tick : '0;
            out_last_q   <= 1'b1;
            st_q         <= S_IDLE;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {out_cval_q, out_cv_q, out_ctx_q, out_tid_q, out_status_q};

endmodule

>>> sv/stq_store.sv
// Timer record and link memories, one read port each with registered data.
module stq_store #(
  parameter int unsigned NUM_TIMERS = stq_pkg::NUM_TIMERS_DEF,
  localparam int unsigned IW = $clog2(NUM_TIMERS),
  localparam int unsigned LW = $clog2(NUM_TIMERS + 1)
) (
  input  logic          clk_i,
  input  logic [IW-1:0] rd_addr_i,
  input  logic          rec_we_i,
  input  logic [IW-1:0] rec_wa_i,
  input  stq_pkg::rec_t rec_wd_i,
  input  logic          link_we_i,
  input  logic [IW-1:0] link_wa_i,
  input  logic [LW-1:0] link_wd_i,
  output stq_pkg::rec_t rec_rd_o,
  output logic [LW-1:0] link_rd_o
);

  stq_pkg::rec_t rec_mem [NUM_TIMERS];
  logic [LW-1:0] link_mem [NUM_TIMERS];

  always_ff @(posedge clk_i) begin
    if (rec_we_i) begin
      rec_mem[rec_wa_i] <= rec_wd_i;
    end
    rec_rd_o <= rec_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (link_we_i) begin
      link_mem[link_wa_i] <= link_wd_i;
    end
    link_rd_o <= link_mem[rd_addr_i];
  end

endmodule

>>> sv/stq_checker.sv
// Port checks of the sorted timer queue and their binding.
module stq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [63:0] m_axis_tdata_o,
  input logic        m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  // a stalled word stays offered
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output word dropped under stall");

  a_report_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> !m_axis_tlast_o)
    else $error("expiry report marked last");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tlast_o)
    else $error("status word not marked last");

  a_report_no_compare: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o[39] == 1'b0 &&
      m_axis_tdata_o[2:0] == 3'd0)
    else $error("expiry report carries compare or status");

endmodule

bind sorted_timer_queue_unit stq_checker u_stq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

>>> sim/tb.sv
// Self-checking testbench for the sorted timer queue unit.
`timescale 1ns / 100ps

module tb;

  localparam int unsigned NT        = stq_pkg::NUM_TIMERS_DEF;
  localparam int unsigned NIL       = NT;
  localparam int unsigned CYCLE_CAP = 2000000;

  // One output word, field by field.
  typedef struct {
    logic                       kind;
    logic [2:0]                 status;
    logic [stq_pkg::IDX_W-1:0]  tid;
    logic [stq_pkg::CTX_W-1:0]  ctx;
    logic                       cmp_valid;
    logic [stq_pkg::TICK_W-1:0] cmp_value;
    logic                       last;
  } timer_word_t;

  // Mirror of the timer pool and running list; holds the words still owed.
  class timer_queue_sb;
    logic [stq_pkg::TICK_W-1:0] min_to;
    logic [stq_pkg::TCNT_W-1:0] tcnt;
    bit                         alloc[NT];
    bit                         rep[NT];
    bit                         run[NT];
    logic [stq_pkg::TICK_W-1:0] etick[NT];
    int unsigned                ewrap[NT];
    logic [stq_pkg::TICK_W-1:0] intv[NT];
    logic [stq_pkg::CTX_W-1:0]  ctx[NT];
    int unsigned                nxt[NT];
    int unsigned                head;
    int unsigned                wraps;
    logic [stq_pkg::TICK_W-1:0] last_cnt;
    timer_word_t                owed[$];
    int unsigned                errors;
    int unsigned                reports;
    int unsigned                items;

    function void clear();
      min_to   = stq_pkg::MIN_TIMEOUT_RST;
      tcnt     = stq_pkg::TIMER_COUNT_RST;
      head     = NIL;
      wraps    = 0;
      last_cnt = '0;
      foreach (alloc[i]) begin
        alloc[i] = 0;
        run[i]   = 0;
        nxt[i]   = NIL;
      end
    endfunction

    function int unsigned in_use();
      return (tcnt > NT) ? NT : tcnt;
    endfunction

    function void take_sample(logic [stq_pkg::TICK_W-1:0] c);
      if (c < last_cnt) wraps++;
      last_cnt = c;
    endfunction

    // Find id in the list; prv gets its predecessor or NIL.
    function bit find_listed(int unsigned id, output int unsigned prv);
      int unsigned cur;
      int unsigned p;
      int unsigned n;
      cur = head;
      p   = NIL;
      n   = 0;
      prv = NIL;
      while (cur < NT && n < NT) begin
        if (cur == id) begin
          prv = p;
          return 1;
        end
        p   = cur;
        cur = nxt[cur];
        n++;
      end
      return 0;
    endfunction

    // Arm id from the last sample and sort it in behind equal expiries.
    function void arm(int unsigned id, logic [stq_pkg::TICK_W-1:0] to,
                      logic [stq_pkg::CTX_W-1:0] cx);
      int unsigned                cur;
      int unsigned                prv;
      int unsigned                n;
      logic [stq_pkg::TICK_W-1:0] t;
      int unsigned                w;
      cur = head;
      prv = NIL;
      n   = 0;
      t   = last_cnt + to;
      w   = wraps;
      if (t < last_cnt) w++;
      intv[id]  = to;
      etick[id] = t;
      ewrap[id] = w;
      run[id]   = 1;
      ctx[id]   = cx;
      while (cur < NT && n < NT) begin
        if (w < ewrap[cur]) break;
        if (w == ewrap[cur] && t < etick[cur]) break;
        prv = cur;
        cur = nxt[cur];
        n++;
      end
      nxt[id] = cur;
      if (prv == NIL) head = id;
      else nxt[prv] = id;
    endfunction

    function bit is_due(int unsigned id);
      if (ewrap[id] == wraps &&
          {2'b00, etick[id]} <= {2'b00, last_cnt} + stq_pkg::DUE_SLACK)
        return 1;
      return ewrap[id] < wraps;
    endfunction

    // Work out the words caused by one accepted action.
    function void note_action(logic [2:0] act, logic [stq_pkg::IDX_W-1:0] idx,
                              logic [stq_pkg::TICK_W-1:0] to, logic rp,
                              logic [stq_pkg::CTX_W-1:0] cx,
                              logic [stq_pkg::TICK_W-1:0] now);
      timer_word_t w;
      logic [2:0]  st;
      logic [3:0]  tid;
      int unsigned cnt;
      int unsigned prv;
      int unsigned pops;
      int unsigned id;
      cnt = in_use();
      st  = stq_pkg::ST_OK;
      tid = '0;
      items++;
      case (act)
        stq_pkg::ACT_CREATE: begin
          st = stq_pkg::ST_NO_FREE;
          for (int i = 0; i < cnt; i++) begin
            if (!alloc[i]) begin
              alloc[i] = 1;
              rep[i]   = rp;
              tid      = 4'(i);
              st       = stq_pkg::ST_OK;
              break;
            end
          end
        end
        stq_pkg::ACT_START: begin
          if (idx >= cnt || to < min_to) st = stq_pkg::ST_INVALID;
          else if (!alloc[idx]) st = stq_pkg::ST_NOT_ALLOC;
          else begin
            take_sample(now);
            if (run[idx] && find_listed(idx, prv)) st = stq_pkg::ST_ALREADY_RUN;
            else arm(idx, to, cx);
          end
        end
        stq_pkg::ACT_STOP: begin
          if (idx >= cnt) st = stq_pkg::ST_INVALID;
          else if (!alloc[idx]) st = stq_pkg::ST_NOT_ALLOC;
          else begin
            run[idx] = 0;
            if (find_listed(idx, prv)) begin
              if (prv == NIL) head = nxt[idx];
              else nxt[prv] = nxt[idx];
              nxt[idx] = NIL;
            end
          end
        end
        stq_pkg::ACT_STOP_ALL: begin
          head = NIL;
          for (int i = 0; i < cnt; i++) begin
            run[i] = 0;
            nxt[i] = NIL;
          end
        end
        stq_pkg::ACT_CHECK: begin
          pops = 0;
          take_sample(now);
          while (head < NT && pops < NT && is_due(head)) begin
            id       = head;
            head     = nxt[id];
            nxt[id]  = NIL;
            if (run[id]) begin
              w = '{stq_pkg::KIND_REPORT, stq_pkg::ST_OK, id[3:0], ctx[id], 1'b0, '0, 1'b0};
              owed.push_back(w);
              reports++;
              if (rep[id]) arm(id, intv[id], ctx[id]);
            end
            pops++;
          end
        end
        default: st = stq_pkg::ST_INVALID;
      endcase
      w = '{stq_pkg::KIND_STATUS, st, tid, '0, 1'b0, '0, 1'b1};
      if (head < NT) begin
        w.cmp_valid = 1'b1;
        w.cmp_value = etick[head];
      end
      owed.push_back(w);
    endfunction

    // Compare one received word with the oldest word owed.
    function void check_word(timer_word_t got);
      timer_word_t exp_w;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected word kind=%0d status=%0d timer=%0d", $realtime,
                   got.kind, got.status, got.tid);
        return;
      end
      exp_w = owed.pop_front();
      if (got.kind !== exp_w.kind || got.status !== exp_w.status || got.tid !== exp_w.tid ||
          got.ctx !== exp_w.ctx || got.cmp_valid !== exp_w.cmp_valid ||
          got.cmp_value !== exp_w.cmp_value || got.last !== exp_w.last) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: mismatch exp kind=%0d st=%0d tmr=%0d ctx=%h cv=%0d cmp=%h last=%0d",
                   $realtime, exp_w.kind, exp_w.status, exp_w.tid, exp_w.ctx,
                   exp_w.cmp_valid, exp_w.cmp_value, exp_w.last);
          $display("%0t:          got kind=%0d st=%0d tmr=%0d ctx=%h cv=%0d cmp=%h last=%0d",
                   $realtime, got.kind, got.status, got.tid, got.ctx,
                   got.cmp_valid, got.cmp_value, got.last);
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_addr_i;
  logic [23:0] cfg_data_i;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  // tdata: timer_index, timeout_len, repeat_mode, user_context, counter_now, pad
  logic [87:0] s_axis_tdata_i;
  // tuser: action
  logic [2:0]  s_axis_tuser_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  // tdata: status, result_timer, expired_context, compare_valid, compare_value
  logic [63:0] m_axis_tdata_o;
  // tuser: kind
  logic        m_axis_tuser_o;
  logic        m_axis_tlast_o;

  timer_queue_sb              sb;
  int unsigned                cycles     = 0;
  int unsigned                burst_left;
  int unsigned                stall_mode = 0;
  int unsigned                mode_left  = 0;
  logic [stq_pkg::TICK_W-1:0] now_cnt;

  sorted_timer_queue_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Sink side: check every accepted word, stall in modes that switch now and then.
  always @(posedge clk_i) begin
    timer_word_t got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.kind      = m_axis_tuser_o;
      got.status    = m_axis_tdata_o[2:0];
      got.tid       = m_axis_tdata_o[6:3];
      got.ctx       = m_axis_tdata_o[38:7];
      got.cmp_valid = m_axis_tdata_o[39];
      got.cmp_value = m_axis_tdata_o[63:40];
      got.last      = m_axis_tlast_o;
      sb.check_word(got);
    end
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      mode_left  <= $urandom_range(30, 300);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0:       m_axis_tready_i <= 1'b1;
      1:       m_axis_tready_i <= ($urandom_range(0, 1) == 0);
      2:       m_axis_tready_i <= ($urandom_range(0, 7) == 0);
      default: m_axis_tready_i <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Offer one word; hold it until the unit takes it, idling between bursts.
  task automatic send_action(input logic [2:0] act, input logic [3:0] idx,
                             input logic [23:0] to, input logic rp,
                             input logic [31:0] cx, input logic [23:0] now);
    if (burst_left == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
      burst_left = $urandom_range(1, 14);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= act;
    s_axis_tdata_i  <= {3'b000, now, cx, rp, to, idx};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.note_action(act, idx, to, rp, cx, now);
    burst_left--;
  endtask

  // Drain all owed words, then let the unit settle.
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic addr, input logic [23:0] val);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= addr;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (addr == stq_pkg::CFG_MIN_TIMEOUT) sb.min_to = val;
    else sb.tcnt = val[stq_pkg::TCNT_W-1:0];
    @(posedge clk_i);
  endtask

  // Advance the counter; now and then jump anywhere, which may look like a wrap.
  task automatic step_counter();
    if ($urandom_range(0, 19) == 0) now_cnt = 24'($urandom);
    else now_cnt = 24'(now_cnt + $urandom_range(0, 1500));
  endtask

  // One random action, mostly sensible starts and checks on a live pool.
  task automatic random_action();
    int unsigned                pick;
    int unsigned                cnt;
    logic [3:0]                 idx;
    logic [stq_pkg::TICK_W-1:0] to;
    pick = $urandom_range(0, 99);
    cnt  = sb.in_use();
    idx  = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, cnt - 1));
    case ($urandom_range(0, 9))
      0:       to = (sb.min_to > 0) ? 24'($urandom_range(0, sb.min_to - 1)) : '0;
      1:       to = 24'($urandom);
      2:       to = 24'(24'hFFFFFF - $urandom_range(0, 3));
      default: to = 24'(sb.min_to + $urandom_range(0, 2500));
    endcase
    if (pick < 12) begin
      send_action(stq_pkg::ACT_CREATE, 4'($urandom), 24'($urandom), 1'($urandom),
                  $urandom, 24'($urandom));
    end else if (pick < 47) begin
      step_counter();
      send_action(stq_pkg::ACT_START, idx, to, 1'($urandom), $urandom, now_cnt);
    end else if (pick < 57) begin
      send_action(stq_pkg::ACT_STOP, idx, 24'($urandom), 1'($urandom), $urandom,
                  24'($urandom));
    end else if (pick < 60) begin
      send_action(stq_pkg::ACT_STOP_ALL, idx, 24'($urandom), 1'($urandom), $urandom,
                  24'($urandom));
    end else if (pick < 95) begin
      step_counter();
      send_action(stq_pkg::ACT_CHECK, idx, 24'($urandom), 1'($urandom), $urandom, now_cnt);
    end else begin
      send_action(3'($urandom_range(5, 7)), idx, to, 1'($urandom), $urandom, 24'($urandom));
    end
  endtask

  initial begin
    logic [23:0] min_set[6];
    logic [23:0] cnt_set[6];
    sb = new();
    sb.clear();
    sb.errors  = 0;
    sb.reports = 0;
    sb.items   = 0;
    burst_left      = 0;
    now_cnt         = '0;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_addr_i      = 1'b0;
    cfg_data_i      = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = '0;
    min_set = '{24'd4, 24'hFFFFFF, 24'd100, 24'd5, 24'd40, 24'd4};
    cnt_set = '{24'd16, 24'd3, 24'd1, 24'd31, 24'd8, 24'd16};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset settings, extremes and each corner of the list logic.
    send_action(stq_pkg::ACT_CREATE, 4'd0, 24'd0, 1'b0, 32'd0, 24'd0);
    send_action(stq_pkg::ACT_CREATE, 4'd0, 24'd0, 1'b1, 32'd0, 24'd0);
    send_action(stq_pkg::ACT_CREATE, 4'd0, 24'd0, 1'b0, 32'd0, 24'd0);
    send_action(stq_pkg::ACT_START, 4'd0, 24'd5, 1'b0, 32'h0000_0000, 24'd100);
    send_action(stq_pkg::ACT_START, 4'd1, 24'hFFFFFF, 1'b1, 32'hFFFF_FFFF, 24'd200);
    send_action(stq_pkg::ACT_START, 4'd2, 24'd4, 1'b0, 32'h1234_5678, 24'd300);
    send_action(stq_pkg::ACT_START, 4'd15, 24'd50, 1'b0, 32'd1, 24'd300);
    send_action(stq_pkg::ACT_START, 4'd0, 24'd50, 1'b0, 32'd2, 24'd310);
    send_action(stq_pkg::ACT_STOP, 4'd3, 24'd0, 1'b0, 32'd0, 24'd0);
    // Single shot expires but keeps its running mark, then re-arms.
    send_action(stq_pkg::ACT_CHECK, 4'd0, 24'd0, 1'b0, 32'd0, 24'd400);
    send_action(stq_pkg::ACT_START, 4'd0, 24'd7, 1'b0, 32'hA5A5_5A5A, 24'd401);
    send_action(stq_pkg::ACT_START, 4'd2, 24'd10, 1'b0, 32'hCAFE_0001, 24'd402);
    // Counter going backwards bumps the wrap: everything older becomes due.
    send_action(stq_pkg::ACT_CHECK, 4'd0, 24'd0, 1'b0, 32'd0, 24'hFFFFFE);
    send_action(stq_pkg::ACT_CHECK, 4'd0, 24'd0, 1'b0, 32'd0, 24'd3);
    send_action(stq_pkg::ACT_STOP, 4'd1, 24'd0, 1'b0, 32'd0, 24'd0);
    send_action(stq_pkg::ACT_STOP, 4'd2, 24'd0, 1'b0, 32'd0, 24'd0);
    send_action(stq_pkg::ACT_START, 4'd1, 24'd9, 1'b1, 32'h0BAD_F00D, 24'd20);
    send_action(stq_pkg::ACT_CHECK, 4'd0, 24'd0, 1'b0, 32'd0, 24'd26);
    send_action(stq_pkg::ACT_CHECK, 4'd0, 24'd0, 1'b0, 32'd0, 24'd40);
    send_action(stq_pkg::ACT_STOP_ALL, 4'd0, 24'd0, 1'b0, 32'd0, 24'd0);
    send_action(3'd7, 4'd0, 24'd0, 1'b0, 32'd0, 24'd0);
    send_action(3'd5, 4'hF, 24'hFFFFFF, 1'b1, 32'hFFFF_FFFF, 24'hFFFFFF);
    now_cnt = 24'd40;
    drain();

    // Random phases under several register settings, extremes included.
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(stq_pkg::CFG_MIN_TIMEOUT, min_set[ph]);
      write_reg(stq_pkg::CFG_TIMER_COUNT, cnt_set[ph]);
      repeat ((ph == 1) ? 20 : 45) random_action();
      drain();
    end

    $display("Covered %0d actions with %0d expiry reports over %0d cycles",
             sb.items, sb.reports, cycles);
    $display("Mismatches: %0d", sb.errors);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
